FILE: rtl/core/ovl_pkg.sv
// Shared types and constants for the ordered value list engine.
// Used by ovl_cell and ordered_value_list_engine; depends on nothing.
package ovl_pkg;

    // Default list depth
    localparam int DEF_CAPACITY = 16;

    // Field widths of the stream items
    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = 5;

    // Request operation codes (6 and 7 are no-ops)
    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_FIND      = 3'd2,
        OP_REMOVE    = 3'd3,
        OP_COUNT     = 3'd4,
        OP_CLEAR     = 3'd5
    } t_op;

    // What every cell of the chain does in the current cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_SWEEP_FIND,
        CELL_SWEEP_REMOVE
    } t_cell_op;

    // Control broadcast to all cells
    typedef struct packed {
        t_cell_op            op;
        logic [VALUE_W-1:0]  key;
    } t_cell_ctl;

endpackage

FILE: rtl/core/ordered_value_list_engine.sv
// Top level of the ordered value list engine: control, count and cell chain.
// Depends on ovl_pkg and ovl_cell.
//
// Usage: requests arrive on the slave stream (operation and value), one
// result leaves on the master stream per request (ok flag and entry count).
// The list lives in a chain of CAPACITY cells, one value per cell.
// Insert front shifts every cell one place right at once; insert back
// writes the cell at the current count; count and clear touch only the
// counter. These give their result in the output register in the cycle
// after the item is taken, so one such item per cycle can flow when the
// receiver keeps up.
// Find and remove send a token down the chain, one cell per cycle, with a
// flag telling whether a match has been seen; on remove each cell at or past
// the first match takes its right neighbor's value as the token passes.
// The result is loaded into the output register once the token reaches
// the last cell of the chain; no new item is taken meanwhile.
// Reset empties the list (count zero) and drops any pending result; cell
// contents are not cleared. A stalled receiver holds the result in the
// output register; a new item is taken only when that register is free or
// being emptied in the same cycle.
module ordered_value_list_engine #(
    parameter int CAPACITY = ovl_pkg::DEF_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] operation, [34:3] value, [39:35] zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] ok, [5:1] entry_count, [7:6] zero
    output logic [7:0]  m_axis_tdata
);
    import ovl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_SWEEP
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic               r_start;
    logic [VALUE_W-1:0] r_key;
    logic               r_remove;
    logic               r_out_valid;
    logic               r_out_ok;
    logic [CNT_W-1:0]   r_out_cnt;

    logic               w_accept;
    t_op                w_op;
    logic [VALUE_W-1:0] w_value;
    logic               w_not_full;
    t_cell_ctl          w_ctl;
    logic               w_done;

    logic [VALUE_W-1:0] w_val  [CAPACITY];
    logic               w_tok  [CAPACITY];
    logic               w_seen [CAPACITY];
    logic [CAPACITY-1:0] w_tok_vec;

    assign w_op       = t_op'(s_axis_tdata[2:0]);
    assign w_value    = s_axis_tdata[34:3];
    assign w_not_full = r_count < CAP_C;

    // Take an item only when idle and the output register will be free
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_done        = (r_state == S_SWEEP) && w_tok[CAPACITY-1];

    // Broadcast control to the cells
    always_comb begin
        w_ctl.op  = CELL_HOLD;
        w_ctl.key = w_value;
        if (r_state == S_SWEEP) begin
            w_ctl.key = r_key;
            w_ctl.op  = r_remove ? CELL_SWEEP_REMOVE : CELL_SWEEP_FIND;
        end else if (w_accept && w_not_full) begin
            case (w_op)
                OP_INS_FRONT: w_ctl.op = CELL_PUSH_FRONT;
                OP_INS_BACK:  w_ctl.op = CELL_PUSH_BACK;
                default:      w_ctl.op = CELL_HOLD;
            endcase
        end
    end

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_W-1:0] w_left;
        logic [VALUE_W-1:0] w_right;
        logic               w_tin;
        logic               w_sin;
        if (g == 0) begin : g_head
            assign w_left = w_ctl.key;
            assign w_tin  = r_start;
            assign w_sin  = 1'b0;
        end else begin : g_body
            assign w_left = w_val[g-1];
            assign w_tin  = w_tok[g-1];
            assign w_sin  = w_seen[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_val[g];
        end else begin : g_mid
            assign w_right = w_val[g+1];
        end
        ovl_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_left_val  (w_left),
            .i_right_val (w_right),
            .i_tok       (w_tin),
            .i_seen      (w_sin),
            .o_val       (w_val[g]),
            .o_tok       (w_tok[g]),
            .o_seen      (w_seen[g])
        );
        assign w_tok_vec[g] = w_tok[g];
    end

    // Sequence requests, keep the count and load results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && m_axis_tready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (w_op)
                            OP_INS_FRONT, OP_INS_BACK: begin
                                r_out_valid <= 1'b1;
                                r_out_ok    <= w_not_full;
                                if (w_not_full) begin
                                    r_count   <= r_count + 1'b1;
                                    r_out_cnt <= CNT_W'(r_count + 1'b1);
                                end else begin
                                    r_out_cnt <= CNT_W'(r_count);
                                end
                            end
                            OP_FIND, OP_REMOVE: begin
                                r_key    <= w_value;
                                r_remove <= (w_op == OP_REMOVE);
                                r_start  <= 1'b1;
                                r_state  <= S_SWEEP;
                            end
                            OP_CLEAR: begin
                                r_count     <= '0;
                                r_out_valid <= 1'b1;
                                r_out_ok    <= 1'b0;
                                r_out_cnt   <= '0;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                                r_out_ok    <= 1'b0;
                                r_out_cnt   <= CNT_W'(r_count);
                            end
                        endcase
                    end
                end
                S_SWEEP: begin
                    if (w_done) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        r_out_ok    <= w_seen[CAPACITY-1];
                        if (r_remove && w_seen[CAPACITY-1]) begin
                            r_count   <= r_count - 1'b1;
                            r_out_cnt <= CNT_W'(r_count - 1'b1);
                        end else begin
                            r_out_cnt <= CNT_W'(r_count);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_cnt, r_out_ok};

    // The count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    // At most one token walks the chain, and only during a sweep
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vec) && (!(|w_tok_vec) || r_state == S_SWEEP))
        else $error("stray token in cell chain");

    // A successful front insert raises the count by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_INS_FRONT && w_not_full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("front insert did not grow the list");

endmodule

FILE: rtl/core/ovl_cell.sv
// One list position of the ordered value list engine.
// Depends on ovl_pkg for the broadcast control struct.
module ovl_cell #(
    parameter int CAPACITY = ovl_pkg::DEF_CAPACITY,
    parameter int IDX      = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ovl_pkg::t_cell_ctl              i_ctl,
    input  logic [$clog2(CAPACITY+1)-1:0]   i_count,
    input  logic [ovl_pkg::VALUE_W-1:0]     i_left_val,
    input  logic [ovl_pkg::VALUE_W-1:0]     i_right_val,
    input  logic                            i_tok,
    input  logic                            i_seen,
    output logic [ovl_pkg::VALUE_W-1:0]     o_val,
    output logic                            o_tok,
    output logic                            o_seen
);
    import ovl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] n_val;
    logic               r_tok;
    logic               r_seen;
    logic               w_hit;
    logic               w_sought;

    // Match only entries inside the list; earlier matches ride in on i_seen
    assign w_hit    = (IDX_C < i_count) && (r_val == i_ctl.key);
    assign w_sought = i_seen || w_hit;

    // Select the next stored value
    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            CELL_PUSH_FRONT: n_val = i_left_val;
            CELL_PUSH_BACK: begin
                if (i_count == IDX_C) n_val = i_ctl.key;
            end
            CELL_SWEEP_REMOVE: begin
                // close up behind the first match as the token passes
                if (i_tok && w_sought) n_val = i_right_val;
            end
            default: n_val = r_val;
        endcase
    end

    // Hold the value, pass token and seen flag to the right neighbor
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_seen <= 1'b0;
        end else begin
            r_tok  <= i_tok;
            r_seen <= i_tok && w_sought;
        end
    end

    assign o_val  = r_val;
    assign o_tok  = r_tok;
    assign o_seen = r_seen;

endmodule

FILE: verif/tb_ordered_value_list_engine.sv
// Self-checking testbench for ordered_value_list_engine: directed and random requests,
// a shadow list that predicts every result, random stalls on both streams.
// Depends on ovl_pkg and the engine RTL.
module tb_ordered_value_list_engine;

    timeunit 1ns;
    timeprecision 1ps;

    import ovl_pkg::*;

    localparam int LIST_DEPTH   = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 150;

    // Operation codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] entry_count;
    } t_list_result;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} t_mix;

    // Shadow copy of the list; predicts one result per accepted request
    class list_shadow;
        int                 depth;
        logic [VALUE_W-1:0] shadow_entries[$];
        t_list_result       awaited_results[$];
        int                 error_count;
        int                 requests_seen;
        int                 results_seen;
        int                 full_refusals;
        int                 search_hits;
        int                 search_misses;
        int                 peak_count;

        function new(int list_depth);
            depth = list_depth;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
            t_list_result expected;
            int           hit_pos;
            expected.ok = 1'b0;
            hit_pos = -1;
            requests_seen++;
            // locate the first matching entry for find and remove
            for (int i = 0; i < shadow_entries.size(); i++) begin
                if (hit_pos < 0 && shadow_entries[i] == value) begin
                    hit_pos = i;
                end
            end
            case (op)
                OP_INS_FRONT, OP_INS_BACK: begin
                    if (shadow_entries.size() < depth) begin
                        if (op == OP_INS_FRONT) begin
                            shadow_entries.push_front(value);
                        end else begin
                            shadow_entries.push_back(value);
                        end
                        expected.ok = 1'b1;
                    end else begin
                        full_refusals++;
                    end
                end
                OP_FIND, OP_REMOVE: begin
                    if (hit_pos >= 0) begin
                        expected.ok = 1'b1;
                        search_hits++;
                        if (op == OP_REMOVE) begin
                            shadow_entries.delete(hit_pos);
                        end
                    end else begin
                        search_misses++;
                    end
                end
                OP_CLEAR: begin
                    shadow_entries.delete();
                end
                default: begin
                end
            endcase
            if (shadow_entries.size() > peak_count) begin
                peak_count = shadow_entries.size();
            end
            expected.entry_count = CNT_W'(shadow_entries.size());
            awaited_results.push_back(expected);
        endfunction

        function void check_result(logic got_ok, logic [CNT_W-1:0] got_count);
            t_list_result expected;
            results_seen++;
            if (awaited_results.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected result: ok=%0d entry_count=%0d", got_ok, got_count);
                end
                return;
            end
            expected = awaited_results.pop_front();
            if (got_ok !== expected.ok || got_count !== expected.entry_count) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("mismatch on result %0d: expected ok=%0d entry_count=%0d,",
                             results_seen, expected.ok, expected.entry_count);
                    $display("    got ok=%0d entry_count=%0d", got_ok, got_count);
                end
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [39:0]                  s_axis_tdata;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [7:0]                   m_axis_tdata;

    list_shadow                   shadow;
    int                           requests_taken;
    int                           cycle_count;
    logic [VALUE_W-1:0]           value_pool[8];

    ordered_value_list_engine #(
        .CAPACITY(LIST_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Offer one request after an optional gap, hold it until the item is taken
    task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        gap = (roll < 60) ? 0 : (roll < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, value, op};
        do @(posedge i_clk); while (!s_axis_tready);
        shadow.note_request(op, value);
        requests_taken++;
    endtask

    // Check every result taken on the master side
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            shadow.check_result(m_axis_tdata[0], m_axis_tdata[5:1]);
        end
    end

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, shadow.awaited_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random ready pattern, plus one long hold-off to back up the block
    initial begin : receiver
        logic ready_level;
        int   run_len;
        int   roll;
        bit   long_hold_done;
        long_hold_done = 0;
        m_axis_tready  = 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (!long_hold_done && requests_taken >= HOLD_AFTER) begin
                long_hold_done = 1;
                ready_level = 1'b0;
                run_len = HOLD_CYCLES;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    ready_level = 1'b1;
                    run_len = $urandom_range(50, 100);
                end else if (roll < 55) begin
                    ready_level = 1'b1;
                    run_len = $urandom_range(1, 20);
                end else if (roll < 92) begin
                    ready_level = 1'b0;
                    run_len = $urandom_range(1, 3);
                end else begin
                    ready_level = 1'b0;
                    run_len = $urandom_range(15, 40);
                end
            end
            m_axis_tready <= ready_level;
            repeat (run_len) @(posedge i_clk);
        end
    end

    // Sender: reset, directed corner cases, then random segments
    initial begin : sender
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        t_mix               mix;
        int                 counted;
        int                 seg_len;
        int                 roll;
        bit                 first_segment;

        shadow         = new(LIST_DEPTH);
        requests_taken = 0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        value_pool[0]  = 32'h8000_0000;
        value_pool[1]  = 32'h7FFF_FFFF;
        value_pool[2]  = 32'h0000_0000;
        value_pool[3]  = 32'hFFFF_FFFF;
        for (int i = 4; i < 8; i++) begin
            value_pool[i] = $urandom;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list: searches miss, count reports zero
        send_request(OP_FIND,      32'h0000_0000);
        send_request(OP_REMOVE,    32'h8000_0000);
        send_request(OP_COUNT,     32'hFFFF_FFFF);
        // extremes at both ends
        send_request(OP_INS_BACK,  32'h7FFF_FFFF);
        send_request(OP_INS_FRONT, 32'h8000_0000);
        send_request(OP_INS_BACK,  32'h0000_0000);
        send_request(OP_INS_FRONT, 32'hFFFF_FFFF);
        send_request(OP_FIND,      32'h8000_0000);
        send_request(OP_FIND,      32'h0000_0001);
        // drop the head, then the tail, then append behind the new tail
        send_request(OP_REMOVE,    32'hFFFF_FFFF);
        send_request(OP_REMOVE,    32'h0000_0000);
        send_request(OP_INS_BACK,  32'h0000_0005);
        send_request(OP_SPARE_6,   32'hFFFF_FFFF);
        send_request(OP_SPARE_7,   32'h5555_AAAA);
        send_request(OP_REMOVE,    32'h0001_2345);
        // duplicates: only the first match goes
        send_request(OP_INS_FRONT, 32'h0000_0009);
        send_request(OP_INS_BACK,  32'h0000_0009);
        send_request(OP_REMOVE,    32'h0000_0009);
        send_request(OP_FIND,      32'h0000_0009);
        send_request(OP_COUNT,     32'h0000_0000);
        // empty the list by removal, then rebuild and clear
        send_request(OP_REMOVE,    32'h8000_0000);
        send_request(OP_REMOVE,    32'h7FFF_FFFF);
        send_request(OP_REMOVE,    32'h0000_0005);
        send_request(OP_REMOVE,    32'h0000_0009);
        send_request(OP_INS_BACK,  32'hAAAA_5555);
        send_request(OP_CLEAR,     32'hAAAA_5555);

        // random segments; the first one fills the list past capacity
        counted = 0;
        first_segment = 1;
        while (counted < RANDOM_ITEMS) begin
            mix = first_segment ? MIX_FILL : t_mix'($urandom_range(0, 3));
            seg_len = first_segment ? 30 : $urandom_range(10, 40);
            first_segment = 0;
            repeat (seg_len) begin
                roll = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL: begin
                        op = (roll < 45) ? OP_INS_FRONT : (roll < 88) ? OP_INS_BACK :
                             (roll < 96) ? OP_FIND : OP_REMOVE;
                    end
                    MIX_DRAIN: begin
                        op = (roll < 60) ? OP_REMOVE : (roll < 80) ? OP_FIND :
                             (roll < 90) ? OP_INS_BACK : (roll < 95) ? OP_INS_FRONT :
                             OP_COUNT;
                    end
                    MIX_BALANCED: begin
                        op = (roll < 25) ? OP_INS_FRONT : (roll < 50) ? OP_INS_BACK :
                             (roll < 70) ? OP_FIND : (roll < 92) ? OP_REMOVE :
                             (roll < 97) ? OP_COUNT : OP_CLEAR;
                    end
                    default: begin
                        op = OP_W'($urandom_range(0, 7));
                    end
                endcase
                // mostly pooled values so searches hit, some fully random
                value = ($urandom_range(0, 3) != 0) ? value_pool[3'($urandom_range(0, 7))]
                                                    : $urandom;
                send_request(op, value);
                if (op != OP_SPARE_6 && op != OP_SPARE_7) begin
                    counted++;
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then allow for a late stray result
        while (shadow.awaited_results.size() != 0) @(posedge i_clk);
        repeat (LIST_DEPTH + 4) @(posedge i_clk);

        if (shadow.awaited_results.size() != 0) begin
            $display("%0d expected results never arrived", shadow.awaited_results.size());
        end
        $display("Run covered %0d requests and %0d results; %0d inserts refused on a full list,",
                 shadow.requests_seen, shadow.results_seen, shadow.full_refusals);
        $display("%0d find/remove hits, %0d misses, peak occupancy %0d, %0d mismatches.",
                 shadow.search_hits, shadow.search_misses, shadow.peak_count,
                 shadow.error_count);
        if (shadow.error_count == 0 && shadow.awaited_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
